// ----- src/assert_macros.svh -----
// Assertion macros shared by the gate RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication-style property on every clock edge out of reset.
`define OAGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal never exceeds a bound out of reset.
`define OAGB_ASSERT_MAX(label, sig, bound, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ((sig) <= (bound))) \
    else $error(msg);

`endif

// ----- src/oagb_pkg.sv -----
// Types, codes and sizes for the ordered admission gate.
// Used by the queue cell, the queue chain and the top level.
package oagb_pkg;

  localparam int NUM_TAGS = 16;
  localparam int TAG_W    = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
  localparam int CNT_W    = $clog2(NUM_TAGS + 1);

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_TRANSFER = 2'd0,
    KIND_POSITION = 2'd1,
    KIND_FLUSH    = 2'd2,
    KIND_CLOSE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_QUEUED = 2'd1,
    PH_ACTIVE = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_PENDING     = 4'd0,
    ST_GRANTED     = 4'd1,
    ST_REJ_CANCEL  = 4'd2,
    ST_REJ_CLOSED  = 4'd3,
    ST_REJ_CLOSING = 4'd4,
    ST_FAULT       = 4'd5,
    ST_CANCELED_Q  = 4'd6,
    ST_NO_EFFECT   = 4'd7,
    ST_RELEASED    = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_SCAN,
    S_ACK,
    S_GRANT
  } state_t;

  typedef struct packed {
    logic [3:0] tag;
    kind_t      kind;
  } entry_t;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [TAG_W-1:0] push_idx;
  } chain_ctrl_t;

endpackage

// ----- src/oagb_cell.sv -----
// One queue cell: holds one entry, takes its neighbor's entry on a shift.
// Depends on oagb_pkg.
module oagb_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            load,
  input  oagb_pkg::entry_t next_entry,
  input  oagb_pkg::entry_t load_entry,
  output oagb_pkg::entry_t entry
);
  import oagb_pkg::*;

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= load_entry;
    end else if (shift) begin
      entry_r <= next_entry;
    end
  end

  assign entry = entry_r;

endmodule

// ----- src/oagb_chain.sv -----
// Row of queue cells: pop shifts toward the head, push writes one place.
// Depends on oagb_pkg and oagb_cell.
module oagb_chain (
  input  logic                  clk,
  input  oagb_pkg::chain_ctrl_t ctrl,
  input  oagb_pkg::entry_t      push_entry,
  output oagb_pkg::entry_t      head
);
  import oagb_pkg::*;

  entry_t cell_q [NUM_TAGS];

  for (genvar i = 0; i < NUM_TAGS; i++) begin : g_cell
    entry_t nxt_in;
    if (i == NUM_TAGS - 1) begin : g_tail
      assign nxt_in = push_entry;
    end else begin : g_body
      assign nxt_in = cell_q[i+1];
    end
    oagb_cell u_cell (
      .clk        (clk),
      .shift      (ctrl.pop),
      .load       (ctrl.push && (ctrl.push_idx == TAG_W'(i))),
      .next_entry (nxt_in),
      .load_entry (push_entry),
      .entry      (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

// ----- src/ordered_admission_gate_with_barriers_top.sv -----
// Ordered admission gate: one request at a time, queue rotated through a cell chain.
// Accepted enqueues and active releases pass through a scan of the queue before the
// acknowledgement; a cancel of a queued tag first passes through a removal pass, then the
// scan; rejected and no-effect requests go straight to the acknowledgement. Grants follow one
// per cycle while out_ready is high. The queue rotation, one entry per cycle, sets the time.
// Reset (synchronous, rst_n low) empties the queue, idles every tag and clears all flags.
`include "assert_macros.svh"
module ordered_admission_gate_with_barriers_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [3:0] in_tag,
  input  logic [1:0] in_req_kind,
  input  logic       in_capacity_ok,
  input  logic       in_capacity_stopped,
  input  logic       in_close_done,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_result_type,
  output logic [3:0] out_result_tag,
  output logic [3:0] out_status,
  output logic       out_gate_closing,
  output logic       out_gate_closed,
  output logic       out_last
);
  import oagb_pkg::*;

  state_t state_r, state_nxt, idle_go;
  logic [CNT_W-1:0] q_cnt_r, q_cnt_nxt, l_cnt_r, l_cnt_nxt, rem_r, rem_nxt;
  logic [CNT_W-1:0] active_r, active_nxt;
  logic stop_r, stop_nxt, keep_r, keep_nxt;
  logic pos_busy_r, pos_busy_nxt, bar_busy_r, bar_busy_nxt;
  logic closing_r, closing_nxt, closed_r, closed_nxt;
  logic skip_r, skip_nxt;
  logic [3:0] op_tag_r, op_tag_nxt;
  status_t status_r, status_nxt;

  phase_t phase_r [NUM_TAGS];
  kind_t  kind_r [NUM_TAGS];
  logic   cancel_r [NUM_TAGS];

  logic phase_we, kind_we, cancel_we, cancel_wd;
  logic [TAG_W-1:0] phase_widx;
  phase_t phase_wd;

  chain_ctrl_t q_ctrl, l_ctrl;
  entry_t q_push, q_head, l_push, l_head;

  logic in_acc, out_acc, in_range, head_bar, head_pos;
  logic [TAG_W-1:0] in_idx;
  phase_t in_phase;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign in_idx   = TAG_W'(in_tag);
  assign in_range = (32'(in_tag) < NUM_TAGS);
  assign in_phase = phase_r[in_idx];
  assign head_bar = (q_head.kind == KIND_FLUSH) || (q_head.kind == KIND_CLOSE);
  assign head_pos = (q_head.kind == KIND_POSITION);

  oagb_chain u_queue (
    .clk        (clk),
    .ctrl       (q_ctrl),
    .push_entry (q_push),
    .head       (q_head)
  );

  oagb_chain u_grants (
    .clk        (clk),
    .ctrl       (l_ctrl),
    .push_entry (l_push),
    .head       (l_head)
  );

  // Datapath and bookkeeping
  always_comb begin
    q_cnt_nxt    = q_cnt_r;
    l_cnt_nxt    = l_cnt_r;
    rem_nxt      = rem_r;
    active_nxt   = active_r;
    stop_nxt     = stop_r;
    keep_nxt     = keep_r;
    pos_busy_nxt = pos_busy_r;
    bar_busy_nxt = bar_busy_r;
    closing_nxt  = closing_r;
    closed_nxt   = closed_r;
    skip_nxt     = skip_r;
    op_tag_nxt   = op_tag_r;
    status_nxt   = status_r;
    idle_go      = S_ACK;
    phase_we     = 1'b0;
    phase_widx   = in_idx;
    phase_wd     = PH_IDLE;
    kind_we      = 1'b0;
    cancel_we    = 1'b0;
    cancel_wd    = 1'b0;
    q_ctrl       = '0;
    l_ctrl       = '0;
    q_push       = q_head;
    l_push       = q_head;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_tag_nxt = in_tag;
          skip_nxt   = 1'b0;
          status_nxt = ST_NO_EFFECT;
          if (in_range) begin
            unique case (op_t'(in_operation))
              OP_ENQUEUE: begin
                if ((in_phase == PH_QUEUED) || (in_phase == PH_ACTIVE)) begin
                  status_nxt = ST_NO_EFFECT;
                end else if (cancel_r[in_idx] || closed_r || closing_r ||
                             !in_capacity_ok) begin
                  priority if (cancel_r[in_idx]) status_nxt = ST_REJ_CANCEL;
                  else if (closed_r)             status_nxt = ST_REJ_CLOSED;
                  else if (closing_r)            status_nxt = ST_REJ_CLOSING;
                  else if (in_capacity_stopped)  status_nxt = ST_REJ_CANCEL;
                  else                           status_nxt = ST_FAULT;
                  phase_we  = 1'b1;
                  phase_wd  = PH_DONE;
                  cancel_we = 1'b1;
                  cancel_wd = 1'b0;
                end else begin
                  kind_we = 1'b1;
                  if (kind_t'(in_req_kind) == KIND_CLOSE) closing_nxt = 1'b1;
                  phase_we        = 1'b1;
                  phase_wd        = PH_QUEUED;
                  q_ctrl.push     = 1'b1;
                  q_ctrl.push_idx = TAG_W'(q_cnt_r);
                  q_push.tag      = in_tag;
                  q_push.kind     = kind_t'(in_req_kind);
                  q_cnt_nxt       = q_cnt_r + 1'b1;
                  status_nxt      = ST_PENDING;
                  skip_nxt        = 1'b1;
                  idle_go         = S_SCAN;
                end
              end
              OP_CANCEL: begin
                cancel_we = 1'b1;
                cancel_wd = 1'b1;
                if (in_phase == PH_QUEUED) begin
                  if (kind_r[in_idx] == KIND_CLOSE) closing_nxt = 1'b0;
                  phase_we   = 1'b1;
                  phase_wd   = PH_DONE;
                  cancel_wd  = 1'b0;
                  rem_nxt    = q_cnt_r;
                  status_nxt = ST_CANCELED_Q;
                  idle_go    = S_REMOVE;
                end
              end
              OP_RELEASE: begin
                if (in_phase == PH_ACTIVE) begin
                  if (active_r != '0) active_nxt = active_r - 1'b1;
                  if (kind_r[in_idx] == KIND_POSITION) pos_busy_nxt = 1'b0;
                  if ((kind_r[in_idx] == KIND_FLUSH) || (kind_r[in_idx] == KIND_CLOSE))
                    bar_busy_nxt = 1'b0;
                  if (kind_r[in_idx] == KIND_CLOSE) begin
                    closed_nxt  = in_close_done;
                    closing_nxt = in_close_done;
                  end
                  phase_we   = 1'b1;
                  phase_wd   = PH_IDLE;
                  cancel_we  = 1'b1;
                  cancel_wd  = 1'b0;
                  status_nxt = ST_RELEASED;
                  idle_go    = S_SCAN;
                end
              end
              default: status_nxt = ST_NO_EFFECT;
            endcase
          end
          if (idle_go == S_SCAN) begin
            rem_nxt  = q_cnt_nxt;
            stop_nxt = bar_busy_nxt;
            keep_nxt = 1'b0;
          end
        end
      end
      S_REMOVE: begin
        if (rem_r != '0) begin
          rem_nxt    = rem_r - 1'b1;
          q_ctrl.pop = 1'b1;
          if (q_head.tag != op_tag_r) begin
            q_ctrl.push     = 1'b1;
            q_ctrl.push_idx = TAG_W'(q_cnt_r - 1'b1);
          end else begin
            q_cnt_nxt = q_cnt_r - 1'b1;
          end
        end else begin
          rem_nxt  = q_cnt_r;
          stop_nxt = bar_busy_r;
          keep_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (rem_r != '0) begin
          rem_nxt    = rem_r - 1'b1;
          q_ctrl.pop = 1'b1;
          q_ctrl.push_idx = TAG_W'(q_cnt_r - 1'b1);
          priority if (stop_r) begin
            q_ctrl.push = 1'b1;
          end else if (head_bar && ((active_r != '0) || keep_r)) begin
            // barrier cannot run yet: hold everything behind it
            stop_nxt    = 1'b1;
            q_ctrl.push = 1'b1;
          end else if (head_pos && pos_busy_r) begin
            keep_nxt    = 1'b1;
            q_ctrl.push = 1'b1;
          end else begin
            q_cnt_nxt  = q_cnt_r - 1'b1;
            phase_we   = 1'b1;
            phase_widx = TAG_W'(q_head.tag);
            phase_wd   = PH_ACTIVE;
            active_nxt = active_r + 1'b1;
            if (head_pos) pos_busy_nxt = 1'b1;
            if (head_bar) begin
              bar_busy_nxt = 1'b1;
              stop_nxt     = 1'b1;
            end
            if (skip_r && (q_head.tag == op_tag_r)) begin
              status_nxt = ST_GRANTED;
            end else begin
              l_ctrl.push     = 1'b1;
              l_ctrl.push_idx = TAG_W'(l_cnt_r);
              l_cnt_nxt       = l_cnt_r + 1'b1;
            end
          end
        end
      end
      S_ACK: begin
      end
      S_GRANT: begin
        if (out_acc) begin
          l_ctrl.pop = 1'b1;
          l_cnt_nxt  = l_cnt_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = idle_go;
      S_REMOVE: if (rem_r == '0) state_nxt = S_SCAN;
      S_SCAN:   if (rem_r == '0) state_nxt = S_ACK;
      S_ACK:    if (out_acc) state_nxt = (l_cnt_r == '0) ? S_IDLE : S_GRANT;
      S_GRANT:  if (out_acc && (l_cnt_r == CNT_W'(1))) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready         = (state_r == S_IDLE);
    out_valid        = (state_r == S_ACK) || (state_r == S_GRANT);
    out_gate_closing = closing_r;
    out_gate_closed  = closed_r;
    if (state_r == S_GRANT) begin
      out_result_type = 1'b1;
      out_result_tag  = l_head.tag;
      out_status      = ST_GRANTED;
      out_last        = (l_cnt_r == CNT_W'(1));
    end else begin
      out_result_type = 1'b0;
      out_result_tag  = op_tag_r;
      out_status      = status_r;
      out_last        = (l_cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      q_cnt_r    <= '0;
      l_cnt_r    <= '0;
      rem_r      <= '0;
      active_r   <= '0;
      stop_r     <= 1'b0;
      keep_r     <= 1'b0;
      pos_busy_r <= 1'b0;
      bar_busy_r <= 1'b0;
      closing_r  <= 1'b0;
      closed_r   <= 1'b0;
      skip_r     <= 1'b0;
      for (int i = 0; i < NUM_TAGS; i++) begin
        phase_r[i]  <= PH_IDLE;
        cancel_r[i] <= 1'b0;
      end
    end else begin
      state_r    <= state_nxt;
      q_cnt_r    <= q_cnt_nxt;
      l_cnt_r    <= l_cnt_nxt;
      rem_r      <= rem_nxt;
      active_r   <= active_nxt;
      stop_r     <= stop_nxt;
      keep_r     <= keep_nxt;
      pos_busy_r <= pos_busy_nxt;
      bar_busy_r <= bar_busy_nxt;
      closing_r  <= closing_nxt;
      closed_r   <= closed_nxt;
      skip_r     <= skip_nxt;
      if (phase_we) phase_r[phase_widx] <= phase_wd;
      if (cancel_we) cancel_r[in_idx] <= cancel_wd;
    end
  end

  always_ff @(posedge clk) begin
    op_tag_r <= op_tag_nxt;
    status_r <= status_nxt;
    if (kind_we) kind_r[in_idx] <= kind_t'(in_req_kind);
  end

  `OAGB_ASSERT(a_ready_xor_valid, !(in_ready && out_valid), "request taken while result pending")
  `OAGB_ASSERT(a_barrier_alone, bar_busy_r |-> (active_r == CNT_W'(1)), "barrier not running alone")
  `OAGB_ASSERT_MAX(a_queue_bound, q_cnt_r, CNT_W'(NUM_TAGS), "queue count overflow")
  `OAGB_ASSERT(a_grant_nonempty, (state_r == S_GRANT) |-> (l_cnt_r != '0), "grant with empty list")

endmodule
